[rtl/pofm_pkg.sv]
package pofm_pkg;

    typedef logic [1:0]  kind_t;
    typedef logic [2:0]  fault_t;
    typedef logic [10:0] frame_id_t;
    typedef logic [47:0] frame_bytes_t;

    localparam kind_t KIND_FRAME  = 2'd0;
    localparam kind_t KIND_TICK   = 2'd1;
    localparam kind_t KIND_PEDAL  = 2'd2;
    localparam kind_t KIND_BUSERR = 2'd3;

    localparam fault_t FAULT_NONE        = 3'd0;
    localparam fault_t FAULT_CHECKSUM    = 3'd1;
    localparam fault_t FAULT_TX_BUSY     = 3'd2;
    localparam fault_t FAULT_BUS         = 3'd3;
    localparam fault_t FAULT_POWER_UP    = 3'd4;
    localparam fault_t FAULT_NO_COMMAND  = 3'd5;
    localparam fault_t FAULT_BAD_RELEASE = 3'd6;

    localparam logic [1:0] REG_COMMAND_ID    = 2'd0;
    localparam logic [1:0] REG_REPORT_ID     = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd2;

    localparam frame_id_t  COMMAND_ID_RESET    = 11'h200;
    localparam frame_id_t  REPORT_ID_RESET     = 11'h201;
    localparam logic [7:0] TIMEOUT_LIMIT_RESET = 8'd10;

    // 8-bit wrapping sum of id high bits, id low byte, 5, 1 and bytes 0..4
    function automatic logic [7:0] frame_sum(input frame_bytes_t bytes, input frame_id_t id);
        logic [7:0] s;
        s = {5'd0, id[10:8]} + id[7:0] + 8'd6;
        s = s + bytes[47:40] + bytes[39:32] + bytes[31:24] + bytes[23:16] + bytes[15:8];
        return s;
    endfunction

endpackage

[rtl/pedal_override_fault_monitor.sv]
// Pedal override and fault monitor.
//
// Input channel (s_*): one item per handshake, of kind command frame, timer
// tick, pedal sample pair or bus error. Result channel (m_*): exactly one
// result item per input item, in order: report frame (ticks only), drive
// values after the override rule and the fault code after the item.
//
// An accepted item lands in an input register; once the result register can
// advance, the checksum, fault update and drive selection are done and the
// result register and the state are loaded. Throughput is one item per cycle
// while the receiver does not stall, set by the single state update per item.
//
// Reset clears the state: fault is startup, commands, pedals and the timeout
// counter are zero, and the id and limit registers take their defaults.
// When the receiver stalls, the result register holds, the input register
// fills and s_ready drops; no item is lost. Configuration writes (cfg_we,
// cfg_index, cfg_data) take effect at once and belong to idle periods.
module pedal_override_fault_monitor
    import pofm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [10:0]  cfg_data,

    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_kind,
    input  logic [10:0]  s_frame_id,
    input  logic [47:0]  s_frame_bytes,
    input  logic         s_transmitter_free,
    input  logic [11:0]  s_sample_a,
    input  logic [11:0]  s_sample_b,

    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_report_valid,
    output logic [47:0]  m_report_bytes,
    output logic [15:0]  m_drive_a,
    output logic [15:0]  m_drive_b,
    output logic [2:0]   m_fault_code
);

    // configuration
    frame_id_t  command_id_reg;
    frame_id_t  report_id_reg;
    logic [7:0] timeout_limit_reg;

    // input register
    logic         in_valid_reg;
    kind_t        in_kind_reg;
    frame_id_t    in_frame_id_reg;
    frame_bytes_t in_bytes_reg;
    logic         in_txfree_reg;
    logic [11:0]  in_sample_a_reg;
    logic [11:0]  in_sample_b_reg;

    // state
    fault_t      fault_reg,     fault_next;
    logic [15:0] command_a_reg, command_a_next;
    logic [15:0] command_b_reg, command_b_next;
    logic [7:0]  tick_count_reg, tick_count_next;
    logic [11:0] pedal_a_reg,   pedal_a_next;
    logic [11:0] pedal_b_reg,   pedal_b_next;

    // result register
    logic         out_valid_reg;
    logic         out_report_valid_reg, out_report_valid_next;
    frame_bytes_t out_report_bytes_reg, out_report_bytes_next;
    logic [15:0]  out_drive_a_reg,      out_drive_a_next;
    logic [15:0]  out_drive_b_reg,      out_drive_b_next;

    logic         advance;
    logic         take;
    frame_bytes_t report_body;
    logic [15:0]  frame_v0;
    logic [15:0]  frame_v1;

    assign advance = !out_valid_reg || m_ready;
    assign take    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    assign frame_v0 = in_bytes_reg[47:32];
    assign frame_v1 = in_bytes_reg[31:16];

    // report uses the fault held before this tick's updates
    assign report_body = {4'd0, pedal_a_reg[11:8], pedal_a_reg[7:0],
                          4'd0, pedal_b_reg[11:8], pedal_b_reg[7:0],
                          5'd0, fault_reg, 8'd0};

    always_comb begin
        fault_next            = fault_reg;
        command_a_next        = command_a_reg;
        command_b_next        = command_b_reg;
        tick_count_next       = tick_count_reg;
        pedal_a_next          = pedal_a_reg;
        pedal_b_next          = pedal_b_reg;
        out_report_valid_next = 1'b0;
        out_report_bytes_next = '0;

        case (in_kind_reg)
            KIND_FRAME: begin
                if (in_frame_id_reg == command_id_reg) begin
                    if (frame_sum(in_bytes_reg, command_id_reg) == in_bytes_reg[7:0]) begin
                        if (in_bytes_reg[15]) begin
                            command_a_next = frame_v0;
                            command_b_next = frame_v1;
                        end else begin
                            fault_next = (frame_v0 == '0 && frame_v1 == '0) ?
                                         FAULT_NONE : FAULT_BAD_RELEASE;
                            command_a_next = '0;
                            command_b_next = '0;
                        end
                        tick_count_next = '0;
                    end else begin
                        fault_next = FAULT_CHECKSUM;
                    end
                end
            end
            KIND_TICK: begin
                if (in_txfree_reg) begin
                    out_report_valid_next = 1'b1;
                    out_report_bytes_next = {report_body[47:8],
                                             frame_sum(report_body, report_id_reg)};
                end else begin
                    fault_next = FAULT_TX_BUSY;
                end
                if (tick_count_reg >= timeout_limit_reg) begin
                    fault_next = FAULT_NO_COMMAND;
                end else begin
                    tick_count_next = tick_count_reg + 8'd1;
                end
            end
            KIND_PEDAL: begin
                pedal_a_next = in_sample_a_reg;
                pedal_b_next = in_sample_b_reg;
            end
            default: begin
                fault_next = FAULT_BUS;
            end
        endcase

        // override rule on the updated state
        if (fault_next == FAULT_NONE) begin
            out_drive_a_next = (command_a_next > {4'd0, pedal_a_next}) ?
                               command_a_next : {4'd0, pedal_a_next};
            out_drive_b_next = (command_b_next > {4'd0, pedal_b_next}) ?
                               command_b_next : {4'd0, pedal_b_next};
        end else begin
            out_drive_a_next = {4'd0, pedal_a_next};
            out_drive_b_next = {4'd0, pedal_b_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            command_id_reg    <= COMMAND_ID_RESET;
            report_id_reg     <= REPORT_ID_RESET;
            timeout_limit_reg <= TIMEOUT_LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_COMMAND_ID:    command_id_reg    <= cfg_data;
                REG_REPORT_ID:     report_id_reg     <= cfg_data;
                REG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_kind_reg     <= s_kind;
            in_frame_id_reg <= s_frame_id;
            in_bytes_reg    <= s_frame_bytes;
            in_txfree_reg   <= s_transmitter_free;
            in_sample_a_reg <= s_sample_a;
            in_sample_b_reg <= s_sample_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_reg      <= FAULT_POWER_UP;
            command_a_reg  <= '0;
            command_b_reg  <= '0;
            tick_count_reg <= '0;
            pedal_a_reg    <= '0;
            pedal_b_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (take) begin
                fault_reg      <= fault_next;
                command_a_reg  <= command_a_next;
                command_b_reg  <= command_b_next;
                tick_count_reg <= tick_count_next;
                pedal_a_reg    <= pedal_a_next;
                pedal_b_reg    <= pedal_b_next;
            end
        end
        if (take) begin
            out_report_valid_reg <= out_report_valid_next;
            out_report_bytes_reg <= out_report_bytes_next;
            out_drive_a_reg      <= out_drive_a_next;
            out_drive_b_reg      <= out_drive_b_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_report_valid = out_report_valid_reg;
    assign m_report_bytes = out_report_bytes_reg;
    assign m_drive_a      = out_drive_a_reg;
    assign m_drive_b      = out_drive_b_reg;
    assign m_fault_code   = fault_reg;

    // a stalled input item must not touch the state
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> $stable(fault_reg) && $stable(tick_count_reg))
        else $error("state changed while the result register was stalled");

    // reports carry no bytes unless flagged
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_report_valid |-> m_report_bytes == '0)
        else $error("report bytes set without a report");

    // with a fault, drive values are raw 12-bit pedal values
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fault_code != FAULT_NONE |->
            m_drive_a[15:12] == '0 && m_drive_b[15:12] == '0)
        else $error("drive exceeds pedal range while faulted");

    // a report holds 12-bit pedal values and a 3-bit fault code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_report_valid |->
            m_report_bytes[47:44] == '0 && m_report_bytes[31:28] == '0 &&
            m_report_bytes[15:11] == '0)
        else $error("report field out of range");

    // an item leaving the input register always reaches the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> out_valid_reg)
        else $error("item dropped between input and result registers");

endmodule
